FILE: design/hid_boot_keyboard_event_generator_assert.svh
// Assertion macros shared by the keyboard event generator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef HID_BOOT_KEYBOARD_EVENT_GENERATOR_ASSERT_SVH
`define HID_BOOT_KEYBOARD_EVENT_GENERATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/hbk_pkg.sv
// Package for the keyboard event generator: constants, command, status and event types.
// Depends on nothing; used by every module of the block.
`default_nettype none
package hbk_pkg;
    localparam int HeldSlotsDefault = 8;
    localparam int NumKeys = 6;
    localparam int NumMods = 8;
    localparam logic [7:0] KeyNumLock = 8'd83;
    localparam logic [7:0] KeyCapsLock = 8'd57;
    localparam logic [7:0] KeyScrollLock = 8'd71;
    localparam logic [7:0] ModUsageBase = 8'd224;
    localparam logic [15:0] RepeatDelayReset = 16'd500;
    localparam logic RegRepeatDelay = 1'b0;

    typedef enum logic [2:0] {
        CMD_NONE, CMD_LOAD, CMD_COMMIT, CMD_TICK, CMD_MOD, CMD_REL, CMD_PRESS, CMD_FLUSH
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op    op;
        logic [2:0] pos;
    } t_cmd;

    typedef struct packed {
        logic step_ok;
        logic same_rpt;
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_TICK, S_MOD, S_REL, S_PRESS, S_FLUSH
    } t_state;

    typedef struct packed {
        logic       kind;
        logic [7:0] code;
        logic       rel;
        logic [7:0] mods;
        logic [2:0] locks;
    } t_event;

    function automatic logic [2:0] lock_bit(input logic [7:0] code);
        logic [2:0] b;
        b = 3'b000;
        priority if (code == KeyNumLock) begin
            b = 3'b001;
        end else if (code == KeyCapsLock) begin
            b = 3'b010;
        end else if (code == KeyScrollLock) begin
            b = 3'b100;
        end
        return b;
    endfunction
endpackage
`default_nettype wire

FILE: design/hbk_ctrl.sv
// Controller of the keyboard event generator: sequences the passes over one item.
// Depends on hbk_pkg.
`default_nettype none
module hbk_ctrl #(
    parameter int HELD_SLOTS = hbk_pkg::HeldSlotsDefault
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    input  wire                           i_op,
    output logic                          o_stall,
    output hbk_pkg::t_cmd                 o_cmd,
    output logic [$clog2(HELD_SLOTS)-1:0] o_slot,
    input  hbk_pkg::t_status              i_status
);
    localparam int SW = $clog2(HELD_SLOTS);
    localparam logic [SW-1:0] LastSlot = SW'(HELD_SLOTS - 1);
    localparam logic [2:0] LastMod = 3'(hbk_pkg::NumMods - 1);
    localparam logic [2:0] LastKey = 3'(hbk_pkg::NumKeys - 1);

    hbk_pkg::t_state r_state, n_state;
    logic [2:0] r_pos, n_pos;
    logic [SW-1:0] r_slot, n_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hbk_pkg::S_IDLE;
            r_pos <= '0;
            r_slot <= '0;
        end else begin
            r_state <= n_state;
            r_pos <= n_pos;
            r_slot <= n_slot;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pos = r_pos;
        n_slot = r_slot;
        o_cmd.op = hbk_pkg::CMD_NONE;
        o_cmd.pos = r_pos;
        o_stall = 1'b1;
        unique case (r_state)
            hbk_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.op = hbk_pkg::CMD_LOAD;
                    n_pos = '0;
                    n_slot = '0;
                    n_state = i_op ? hbk_pkg::S_TICK : hbk_pkg::S_CHECK;
                end
            end
            hbk_pkg::S_CHECK: begin
                if (i_status.same_rpt) begin
                    n_state = hbk_pkg::S_IDLE;
                end else begin
                    o_cmd.op = hbk_pkg::CMD_COMMIT;
                    n_state = hbk_pkg::S_MOD;
                end
            end
            hbk_pkg::S_TICK: begin
                o_cmd.op = hbk_pkg::CMD_TICK;
                if (i_status.step_ok) begin
                    if (r_slot == LastSlot) begin
                        n_state = hbk_pkg::S_FLUSH;
                    end else begin
                        n_slot = r_slot + 1'b1;
                    end
                end
            end
            hbk_pkg::S_MOD: begin
                o_cmd.op = hbk_pkg::CMD_MOD;
                if (i_status.step_ok) begin
                    if (r_pos == LastMod) begin
                        n_pos = '0;
                        n_state = hbk_pkg::S_REL;
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
            end
            hbk_pkg::S_REL: begin
                o_cmd.op = hbk_pkg::CMD_REL;
                if (i_status.step_ok) begin
                    if (r_slot == LastSlot) begin
                        n_slot = '0;
                        n_state = hbk_pkg::S_PRESS;
                    end else begin
                        n_slot = r_slot + 1'b1;
                    end
                end
            end
            hbk_pkg::S_PRESS: begin
                o_cmd.op = hbk_pkg::CMD_PRESS;
                if (i_status.step_ok) begin
                    if (r_pos == LastKey) begin
                        n_state = hbk_pkg::S_FLUSH;
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
            end
            hbk_pkg::S_FLUSH: begin
                o_cmd.op = hbk_pkg::CMD_FLUSH;
                if (i_status.step_ok) begin
                    n_state = hbk_pkg::S_IDLE;
                end
            end
            default: n_state = hbk_pkg::S_IDLE;
        endcase
    end

    assign o_slot = r_slot;
endmodule
`default_nettype wire

FILE: design/hbk_dpath.sv
// Datapath of the keyboard event generator: report, slot table, lock status and output stages.
// Depends on hbk_pkg and the assertion macro header.
`default_nettype none
`include "hid_boot_keyboard_event_generator_assert.svh"
module hbk_dpath #(
    parameter int HELD_SLOTS = hbk_pkg::HeldSlotsDefault
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  hbk_pkg::t_cmd                 i_cmd,
    input  wire [$clog2(HELD_SLOTS)-1:0]  i_slot,
    output hbk_pkg::t_status              o_status,
    input  wire [15:0]                    i_repeat_delay,
    input  wire [7:0]                     i_modifier_byte,
    input  wire [7:0]                     i_key0,
    input  wire [7:0]                     i_key1,
    input  wire [7:0]                     i_key2,
    input  wire [7:0]                     i_key3,
    input  wire [7:0]                     i_key4,
    input  wire [7:0]                     i_key5,
    input  wire [31:0]                    i_now_ticks,
    input  wire                           i_out_stall,
    output logic                          o_out_valid,
    output logic                          o_event_kind,
    output logic [7:0]                    o_key_code,
    output logic                          o_is_release,
    output logic [7:0]                    o_mod_flags,
    output logic [2:0]                    o_lock_flags,
    output logic                          o_last
);
    localparam int SW = $clog2(HELD_SLOTS);
    localparam int NK = hbk_pkg::NumKeys;

    logic [55:0] r_prev;
    logic [7:0] r_newmods, r_mods0, r_kmods;
    logic [7:0] r_keys [NK];
    logic [31:0] r_now;
    logic [2:0] r_locks0, r_lock;
    logic [HELD_SLOTS-1:0] r_valid;
    logic [7:0] r_code [HELD_SLOTS];
    logic [31:0] r_dl [HELD_SLOTS];
    hbk_pkg::t_event r_hold, r_out;
    logic r_hold_v, r_out_v, r_out_last;

    logic [55:0] rep;
    logic [NK-1:0] lmask;
    logic run, inl, hit, ffound, pactive, ev, rel_cond, fill, out_free, mv, step_ok;
    logic [7:0] sel_code, pkey, kmods_n;
    logic [2:0] lb;
    logic [SW-1:0] fslot;
    hbk_pkg::t_event evt;

    assign rep = {r_keys[5], r_keys[4], r_keys[3], r_keys[2], r_keys[1], r_keys[0], r_newmods};
    assign sel_code = r_code[i_slot];
    assign pactive = (i_cmd.pos < 3'(NK)) && lmask[i_cmd.pos];
    assign pkey = (i_cmd.pos < 3'(NK)) ? r_keys[i_cmd.pos] : 8'd0;
    assign lb = hbk_pkg::lock_bit(pkey);

    always_comb begin
        run = !((r_keys[0] != 8'd0) && (r_keys[0] == r_keys[1]));
        inl = 1'b0;
        for (int i = 0; i < NK; i++) begin
            run = run && (r_keys[i] != 8'd0);
            lmask[i] = run;
            inl = inl | (run && (r_keys[i] == sel_code));
        end
        hit = 1'b0;
        ffound = 1'b0;
        fslot = '0;
        for (int j = HELD_SLOTS - 1; j >= 0; j--) begin
            hit = hit | (r_valid[j] && (r_code[j] == pkey));
            if (!r_valid[j]) begin
                ffound = 1'b1;
                fslot = SW'(j);
            end
        end
    end

    always_comb begin
        ev = 1'b0;
        rel_cond = 1'b0;
        fill = 1'b0;
        kmods_n = r_kmods;
        evt = '0;
        unique case (i_cmd.op)
            hbk_pkg::CMD_TICK: begin
                ev = r_valid[i_slot] && (r_dl[i_slot] < r_now)
                    && (hbk_pkg::lock_bit(sel_code) == 3'b000);
                evt.code = sel_code;
                evt.mods = r_mods0;
                evt.locks = r_locks0;
            end
            hbk_pkg::CMD_MOD: begin
                evt.rel = !r_newmods[i_cmd.pos];
                if (evt.rel) begin
                    kmods_n = r_kmods & ~(8'd1 << i_cmd.pos);
                end
                ev = r_mods0[i_cmd.pos] ^ r_newmods[i_cmd.pos];
                evt.code = hbk_pkg::ModUsageBase + 8'(i_cmd.pos);
                evt.mods = kmods_n;
                evt.locks = r_locks0;
            end
            hbk_pkg::CMD_REL: begin
                rel_cond = r_valid[i_slot] && !inl;
                ev = rel_cond && (hbk_pkg::lock_bit(sel_code) == 3'b000);
                evt.code = sel_code;
                evt.rel = 1'b1;
                evt.mods = r_newmods;
                evt.locks = r_locks0;
            end
            hbk_pkg::CMD_PRESS: begin
                fill = pactive && !hit && ffound;
                ev = fill;
                evt.code = pkey;
                evt.mods = r_kmods;
                if (lb != 3'b000) begin
                    evt.kind = 1'b1;
                    evt.locks = r_lock ^ lb;
                end else begin
                    evt.locks = r_locks0;
                end
            end
            default: ev = 1'b0;
        endcase
    end

    assign out_free = !r_out_v || !i_out_stall;
    assign step_ok = (i_cmd.op == hbk_pkg::CMD_FLUSH) ? (!r_hold_v || out_free)
                                                      : (!ev || !r_hold_v || out_free);
    assign mv = r_hold_v && out_free && (ev || (i_cmd.op == hbk_pkg::CMD_FLUSH));
    assign o_status.step_ok = step_ok;
    assign o_status.same_rpt = (rep == r_prev);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_valid <= '0;
            r_lock <= '0;
            r_hold_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (mv) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
            if (ev && step_ok) begin
                r_hold_v <= 1'b1;
            end else if (mv) begin
                r_hold_v <= 1'b0;
            end
            if (i_cmd.op == hbk_pkg::CMD_COMMIT) begin
                r_prev <= rep;
            end
            if (rel_cond && step_ok) begin
                r_valid[i_slot] <= 1'b0;
            end
            if (fill && step_ok) begin
                r_valid[fslot] <= 1'b1;
                r_lock <= r_lock ^ lb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == hbk_pkg::CMD_LOAD) begin
            r_newmods <= i_modifier_byte;
            r_keys[0] <= i_key0;
            r_keys[1] <= i_key1;
            r_keys[2] <= i_key2;
            r_keys[3] <= i_key3;
            r_keys[4] <= i_key4;
            r_keys[5] <= i_key5;
            r_now <= i_now_ticks;
            r_mods0 <= r_prev[7:0];
            r_kmods <= r_prev[7:0];
            r_locks0 <= r_lock;
        end
        if ((i_cmd.op == hbk_pkg::CMD_MOD) && step_ok) begin
            r_kmods <= kmods_n;
        end
        if (fill && step_ok) begin
            r_code[fslot] <= pkey;
            r_dl[fslot] <= r_now + {16'd0, i_repeat_delay};
        end
        if (ev && step_ok) begin
            r_hold <= evt;
        end
        if (mv) begin
            r_out <= r_hold;
            r_out_last <= (i_cmd.op == hbk_pkg::CMD_FLUSH);
        end
    end

    assign o_out_valid = r_out_v;
    assign o_event_kind = r_out.kind;
    assign o_key_code = r_out.code;
    assign o_is_release = r_out.rel;
    assign o_mod_flags = r_out.mods;
    assign o_lock_flags = r_out.locks;
    assign o_last = r_out_last;

    `ASSERT_IMP(a_load_hold_empty, i_clk, i_rst_n, (i_cmd.op == hbk_pkg::CMD_LOAD), !r_hold_v)
    `ASSERT_NXT(a_tick_keeps_slots, i_clk, i_rst_n, (i_cmd.op == hbk_pkg::CMD_TICK), $stable(r_valid))
    `ASSERT_NXT(a_rel_no_fill, i_clk, i_rst_n, (i_cmd.op == hbk_pkg::CMD_REL), ((r_valid & ~$past(r_valid)) == '0))
    `ASSERT_NXT(a_flush_marks_last, i_clk, i_rst_n, ((i_cmd.op == hbk_pkg::CMD_FLUSH) && r_hold_v && out_free), (r_out_v && r_out_last && !r_hold_v))
endmodule
`default_nettype wire

FILE: design/hid_boot_keyboard_event_generator.sv
// A report runs the check, modifier, slot, key and flush passes, a tick the slot and flush
// passes, both held while the output is stalled; an unchanged report ends after the check.
// Throughput: one item at a time, set by the controller's modifier, slot and key passes.
// Reset: synchronous, active low; clears held slots, lock status, previous report, outputs.
// Depends on hbk_pkg, hbk_ctrl and hbk_dpath.
`default_nettype none
module hid_boot_keyboard_event_generator #(
    parameter int HELD_SLOTS = hbk_pkg::HeldSlotsDefault
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        psel,
    input  wire        penable,
    input  wire        pwrite,
    input  wire [2:0]  paddr,
    input  wire [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready,
    input  wire        i_valid,
    output logic       o_stall,
    input  wire        i_op,
    input  wire [7:0]  i_modifier_byte,
    input  wire [7:0]  i_key0,
    input  wire [7:0]  i_key1,
    input  wire [7:0]  i_key2,
    input  wire [7:0]  i_key3,
    input  wire [7:0]  i_key4,
    input  wire [7:0]  i_key5,
    input  wire [31:0] i_now_ticks,
    output logic       o_valid,
    input  wire        i_stall,
    output logic       o_event_kind,
    output logic [7:0] o_key_code,
    output logic       o_is_release,
    output logic [7:0] o_mod_flags,
    output logic [2:0] o_lock_flags,
    output logic       o_last
);
    logic [15:0] r_repeat_delay;
    hbk_pkg::t_cmd cmd;
    hbk_pkg::t_status status;
    logic [$clog2(HELD_SLOTS)-1:0] slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_delay <= hbk_pkg::RepeatDelayReset;
        end else if (psel && penable && pwrite && (paddr[2] == hbk_pkg::RegRepeatDelay)) begin
            r_repeat_delay <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == hbk_pkg::RegRepeatDelay) ? {16'd0, r_repeat_delay} : 32'd0;

    hbk_ctrl #(.HELD_SLOTS(HELD_SLOTS)) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_op     (i_op),
        .o_stall  (o_stall),
        .o_cmd    (cmd),
        .o_slot   (slot),
        .i_status (status)
    );

    hbk_dpath #(.HELD_SLOTS(HELD_SLOTS)) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_slot          (slot),
        .o_status        (status),
        .i_repeat_delay  (r_repeat_delay),
        .i_modifier_byte (i_modifier_byte),
        .i_key0          (i_key0),
        .i_key1          (i_key1),
        .i_key2          (i_key2),
        .i_key3          (i_key3),
        .i_key4          (i_key4),
        .i_key5          (i_key5),
        .i_now_ticks     (i_now_ticks),
        .i_out_stall     (i_stall),
        .o_out_valid     (o_valid),
        .o_event_kind    (o_event_kind),
        .o_key_code      (o_key_code),
        .o_is_release    (o_is_release),
        .o_mod_flags     (o_mod_flags),
        .o_lock_flags    (o_lock_flags),
        .o_last          (o_last)
    );
endmodule
`default_nettype wire

FILE: tb/hbk_event_checker.sv
// Checker for the keyboard event generator: watches both channels and the register port.
// Predicts the event stream of each accepted transfer and compares it field by field.
// Depends on hbk_pkg for the slot count, lock key, modifier usage and register constants.
`timescale 1ns / 100ps
`default_nettype none
module hbk_event_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        psel,
    input  wire        penable,
    input  wire        pwrite,
    input  wire [2:0]  paddr,
    input  wire [31:0] pwdata,
    input  wire        pready,
    input  wire        i_valid,
    input  wire        o_stall,
    input  wire        i_op,
    input  wire [7:0]  i_modifier_byte,
    input  wire [7:0]  i_key0,
    input  wire [7:0]  i_key1,
    input  wire [7:0]  i_key2,
    input  wire [7:0]  i_key3,
    input  wire [7:0]  i_key4,
    input  wire [7:0]  i_key5,
    input  wire [31:0] i_now_ticks,
    input  wire        o_valid,
    input  wire        i_stall,
    input  wire        o_event_kind,
    input  wire [7:0]  o_key_code,
    input  wire        o_is_release,
    input  wire [7:0]  o_mod_flags,
    input  wire [2:0]  o_lock_flags,
    input  wire        o_last,
    output int         o_fail_count,
    output int         o_pending
);
    localparam int Slots = hbk_pkg::HeldSlotsDefault;

    typedef struct packed {
        logic       kind;
        logic [7:0] code;
        logic       rel;
        logic [7:0] mods;
        logic [2:0] locks;
        logic       last;
    } t_key_event;

    t_key_event  expected_events[$];
    logic [15:0] delay_reg;
    logic [55:0] prev_report;
    logic [7:0]  slot_code[Slots];
    logic        slot_held[Slots];
    logic [31:0] slot_deadline[Slots];
    logic [2:0]  lock_state;
    int          fail_count;

    assign o_fail_count = fail_count;

    function automatic logic [2:0] lock_mask(input logic [7:0] code);
        if (code == hbk_pkg::KeyNumLock) return 3'b001;
        if (code == hbk_pkg::KeyCapsLock) return 3'b010;
        if (code == hbk_pkg::KeyScrollLock) return 3'b100;
        return 3'b000;
    endfunction

    task automatic push_event(input logic kind, input logic [7:0] code, input logic rel,
                              input logic [7:0] mods, input logic [2:0] locks);
        t_key_event ev;
        ev = '{kind, code, rel, mods, locks, 1'b0};
        expected_events.push_back(ev);
    endtask

    task automatic predict_events(input logic op, input logic [7:0] newmods,
                                  input logic [7:0] keys[6], input logic [31:0] now);
        int          before_count;
        int          num;
        logic [7:0]  list[6];
        logic [7:0]  curmods;
        logic [7:0]  kmods;
        logic [2:0]  locks;
        logic [2:0]  lb;
        logic [55:0] rep;
        bit          found;
        t_key_event  ev;
        before_count = expected_events.size();
        curmods = prev_report[7:0];
        kmods = curmods;
        locks = lock_state;
        num = 0;
        if (op) begin
            for (int j = 0; j < Slots; j++)
                if (slot_held[j] && slot_deadline[j] < now && lock_mask(slot_code[j]) == 0)
                    push_event(1'b0, slot_code[j], 1'b0, curmods, locks);
        end else begin
            rep = {keys[5], keys[4], keys[3], keys[2], keys[1], keys[0], newmods};
            if (rep == prev_report) return;
            prev_report = rep;
            for (int i = 0; i < 8; i++) begin
                if (curmods[i] != newmods[i]) begin
                    if (!newmods[i]) kmods[i] = 1'b0;
                    push_event(1'b0, hbk_pkg::ModUsageBase + 8'(i), !newmods[i], kmods,
                               locks);
                end
            end
            if (keys[0] != keys[1] || keys[0] == 0) begin
                for (int i = 0; i < 6; i++) begin
                    if (keys[i] == 0) break;
                    list[num] = keys[i];
                    num++;
                end
            end
            for (int j = 0; j < Slots; j++) begin
                if (!slot_held[j]) continue;
                found = 0;
                for (int i = 0; i < num; i++) if (list[i] == slot_code[j]) found = 1;
                if (!found) begin
                    slot_held[j] = 1'b0;
                    if (lock_mask(slot_code[j]) == 0)
                        push_event(1'b0, slot_code[j], 1'b1, newmods, locks);
                end
            end
            for (int i = 0; i < num; i++) begin
                found = 0;
                for (int j = 0; j < Slots; j++)
                    if (slot_held[j] && slot_code[j] == list[i]) found = 1;
                if (found) continue;
                for (int j = 0; j < Slots; j++) begin
                    if (!slot_held[j]) begin
                        lb = lock_mask(list[i]);
                        slot_held[j] = 1'b1;
                        slot_code[j] = list[i];
                        slot_deadline[j] = now + 32'(delay_reg);
                        if (lb != 0) begin
                            lock_state = lock_state ^ lb;
                            push_event(1'b1, list[i], 1'b0, kmods, lock_state);
                        end else begin
                            push_event(1'b0, list[i], 1'b0, kmods, locks);
                        end
                        break;
                    end
                end
            end
        end
        if (expected_events.size() > before_count) begin
            ev = expected_events.pop_back();
            ev.last = 1'b1;
            expected_events.push_back(ev);
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        logic [7:0] keys[6];
        t_key_event got;
        t_key_event want;
        if (!i_rst_n) begin
            delay_reg = hbk_pkg::RepeatDelayReset;
            prev_report = '0;
            lock_state = '0;
            for (int j = 0; j < Slots; j++) begin
                slot_held[j] = 1'b0;
                slot_code[j] = '0;
                slot_deadline[j] = '0;
            end
            expected_events.delete();
            fail_count = 0;
        end else begin
            if (psel && penable && pwrite && pready
                && paddr == {hbk_pkg::RegRepeatDelay, 2'b00})
                delay_reg = pwdata[15:0];
            if (i_valid && !o_stall) begin
                keys = '{i_key0, i_key1, i_key2, i_key3, i_key4, i_key5};
                predict_events(i_op, i_modifier_byte, keys, i_now_ticks);
            end
            if (o_valid && !i_stall) begin
                got = '{o_event_kind, o_key_code, o_is_release, o_mod_flags, o_lock_flags,
                        o_last};
                if (expected_events.size() == 0) begin
                    report_mismatch($sformatf("unexpected event %h", got));
                end else begin
                    want = expected_events.pop_front();
                    if (got.kind !== want.kind)
                        report_mismatch($sformatf("kind %b want %b", got.kind, want.kind));
                    if (got.code !== want.code)
                        report_mismatch($sformatf("code %0d want %0d", got.code, want.code));
                    if (got.rel !== want.rel)
                        report_mismatch($sformatf("release %b want %b", got.rel, want.rel));
                    if (got.mods !== want.mods)
                        report_mismatch($sformatf("mods %h want %h", got.mods, want.mods));
                    if (got.locks !== want.locks)
                        report_mismatch($sformatf("locks %b want %b", got.locks, want.locks));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last %b want %b", got.last, want.last));
                end
            end
        end
        o_pending = expected_events.size();
    end
endmodule
`default_nettype wire

FILE: tb/tb_hid_boot_keyboard_event_generator.sv
// Top of the keyboard event generator testbench: clock, reset, register writes and stimulus.
// Depends on hbk_pkg, the block and hbk_event_checker, which predicts and compares.
`timescale 1ns / 100ps
`default_nettype none
module tb_hid_boot_keyboard_event_generator;
    localparam int SettleCycles = 60;
    localparam int HoldOffCycles = 600;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid;
    logic        o_stall;
    logic        i_op;
    logic [7:0]  i_modifier_byte;
    logic [7:0]  i_key0, i_key1, i_key2, i_key3, i_key4, i_key5;
    logic [31:0] i_now_ticks;
    logic        o_valid;
    logic        i_stall;
    logic        o_event_kind;
    logic [7:0]  o_key_code;
    logic        o_is_release;
    logic [7:0]  o_mod_flags;
    logic [2:0]  o_lock_flags;
    logic        o_last;
    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_request;
    int          hold_served;
    int          hold_cycles;
    logic [31:0] clock_ticks;

    hid_boot_keyboard_event_generator u_top (.*);

    hbk_event_checker u_checker (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .i_valid, .o_stall, .i_op, .i_modifier_byte, .i_key0, .i_key1, .i_key2,
        .i_key3, .i_key4, .i_key5, .i_now_ticks, .o_valid, .i_stall, .o_event_kind,
        .o_key_code, .o_is_release, .o_mod_flags, .o_lock_flags, .o_last,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    // The receiver stalls at random, or solidly while a hold-off count runs.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            hold_cycles <= 0;
            hold_served <= 0;
        end else if (hold_served != hold_request) begin
            hold_served <= hold_request;
            hold_cycles <= HoldOffCycles - 1;
            i_stall <= 1'b1;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic write_delay(input logic [15:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {hbk_pkg::RegRepeatDelay, 2'b00};
        pwdata <= {16'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic send_item(input logic op, input logic [7:0] mods, input logic [7:0] k[6],
                             input logic [31:0] now);
        @(posedge i_clk);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        i_valid <= 1'b1;
        i_op <= op;
        i_modifier_byte <= mods;
        {i_key0, i_key1, i_key2, i_key3, i_key4, i_key5} <= {k[0], k[1], k[2], k[3], k[4], k[5]};
        i_now_ticks <= now;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic send_report(input logic [7:0] mods, input logic [7:0] k[6]);
        clock_ticks = clock_ticks + $urandom_range(40);
        send_item(1'b0, mods, k, clock_ticks);
    endtask

    task automatic send_tick(input logic [31:0] now);
        logic [7:0] k[6];
        k = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom)};
        send_item(1'b1, 8'($urandom), k, now);
    endtask

    task automatic random_report();
        logic [7:0] pool[12];
        logic [7:0] k[6];
        int         n;
        pool = '{hbk_pkg::KeyNumLock, hbk_pkg::KeyCapsLock, hbk_pkg::KeyScrollLock, 8'd4,
                 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10, 8'd255, 8'd128};
        k = '{default: 8'd0};
        n = $urandom_range(6);
        for (int i = 0; i < n; i++)
            k[i] = ($urandom_range(9) == 0) ? 8'($urandom_range(1, 255))
                                             : pool[$urandom_range(11)];
        if ($urandom_range(15) == 0) begin
            k[1] = k[0];
        end else if ($urandom_range(15) == 0) begin
            k[$urandom_range(5)] = 8'($urandom);
        end
        send_report(($urandom_range(1) == 0) ? 8'($urandom) : 8'($urandom_range(3)), k);
    endtask

    task automatic random_phase(input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(4) == 0) send_tick(clock_ticks + $urandom_range(800));
            else random_report();
        end
    endtask

    initial begin
        logic [7:0] k[6];
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_valid = 1'b0;
        i_op = 1'b0;
        i_modifier_byte = '0;
        {i_key0, i_key1, i_key2, i_key3, i_key4, i_key5} = '0;
        i_now_ticks = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 0;
        clock_ticks = 32'd1000;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_delay(16'd0);
        k = '{8'd4, 8'd255, hbk_pkg::KeyNumLock, hbk_pkg::KeyCapsLock, hbk_pkg::KeyScrollLock,
              8'd1};
        send_report(8'hFF, k);
        send_report(8'hFF, k);
        k = '{8'd4, 8'd255, 8'd0, 8'd9, 8'd10, 8'd11};
        send_report(8'h00, k);
        send_tick(32'hFFFF_FFFF);
        send_tick(32'd0);
        k = '{8'd20, 8'd20, 8'd21, 8'd0, 8'd0, 8'd0};
        send_report(8'hA5, k);
        k = '{8'd30, 8'd31, 8'd32, 8'd33, 8'd34, 8'd35};
        send_report(8'h5A, k);
        k = '{8'd36, 8'd37, 8'd38, 8'd39, 8'd40, 8'd40};
        send_report(8'h5A, k);
        k = '{8'd0, 8'd50, 8'd51, 8'd0, 8'd0, 8'd0};
        send_report(8'h00, k);
        k = '{hbk_pkg::KeyCapsLock, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
        send_report(8'h01, k);
        send_tick(32'hFFFF_FFFF);
        k = '{default: 8'd0};
        send_report(8'h00, k);
        wait_drained();

        write_delay(16'hFFFF);
        k = '{8'd60, 8'd61, 8'd0, 8'd0, 8'd0, 8'd0};
        clock_ticks = 32'hFFFF_FF00;
        send_item(1'b0, 8'h80, k, clock_ticks);
        send_tick(32'hFFFF_FFFF);
        send_tick(32'd5);
        clock_ticks = 32'd2000;
        wait_drained();

        write_delay(16'd100);
        send_idle_pct = 10;
        recv_idle_pct = 67;
        random_phase(70);
        wait_drained();

        // Long receiver hold-off while items keep arriving.
        hold_request = hold_request + 1;
        recv_idle_pct = 0;
        send_idle_pct = 0;
        random_phase(15);
        wait_drained();

        write_delay(hbk_pkg::RepeatDelayReset);
        send_idle_pct = 67;
        recv_idle_pct = 10;
        random_phase(60);
        wait_drained();

        write_delay(16'd3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(60);
        wait_drained();

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
